### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ISR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ISR_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### src/isr_pkg.sv
// ----------------------------------------------------------------------------
// isr_pkg
// Types and constants shared by the integer square root unit.
// ----------------------------------------------------------------------------
package isr_pkg;

	// Default radicand width used by the recurrence.
	localparam int DATA_WIDTH_DEF = 64;

	// Width of the value field on the input stream.
	localparam int VALUE_WIDTH = 64;

	// Width of the root field on the output stream.
	localparam int ROOT_WIDTH = 32;

	// One finished result.
	typedef struct packed {
		logic                  negative_error;
		logic [ROOT_WIDTH-1:0] root;
	} result_t;

	// A result together with its valid bit, as it leaves the pipeline.
	typedef struct packed {
		logic    valid;
		result_t result;
	} beat_t;

endpackage

### src/integer_square_root_unit.sv
// ----------------------------------------------------------------------------
// integer_square_root_unit
// Pipelined floor square root of a signed integer, one transaction per cycle while the output keeps up.
// ----------------------------------------------------------------------------
// The unit takes one signed radicand per stream transaction and returns the
// square root truncated toward zero. Only the low DATA_WIDTH bits of the
// input take part, read as a two's complement number; a negative radicand
// yields a root of zero with negative_error set. The restoring bit-pair
// recurrence is laid out as a chain of (DATA_WIDTH-2)/2+1 register stages,
// one compare-and-subtract per stage, followed by an output register with a
// skid entry. A new transaction is taken every cycle while the output side
// keeps up, so sustained throughput is one result per clock. A transaction
// is captured by the first stage register when it is accepted, moves
// through each later stage register in turn, and reaches the output
// register after the last stage. When the output is stalled the skid entry
// absorbs the transaction in flight and the stage chain then holds, so
// nothing is dropped or repeated. The unit keeps no state between
// transactions.
// ----------------------------------------------------------------------------
module integer_square_root_unit #(
	parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_axis_tdata: value [63:0]
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [isr_pkg::VALUE_WIDTH-1:0] s_axis_tdata,
	// m_axis_tdata: root [31:0]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [isr_pkg::ROOT_WIDTH-1:0]  m_axis_tdata,
	// m_axis_tuser: negative_error [0]
	output logic                            m_axis_tuser
);

	logic             pipe_en;
	isr_pkg::beat_t   tail;
	isr_pkg::result_t out_result;

	// The stage chain advances whenever the skid entry is free; that same
	// signal is the input ready, so it is a registered term with no path
	// from the output ready.
	assign s_axis_tready = pipe_en;

	isr_pipe #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (s_axis_tvalid),
		.value    (s_axis_tdata),
		.tail     (tail)
	);

	isr_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.tail       (tail),
		.ready      (pipe_en),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	assign m_axis_tdata = out_result.root;
	assign m_axis_tuser = out_result.negative_error;

endmodule

### src/isr_step.sv
// ----------------------------------------------------------------------------
// isr_step
// One step of the restoring bit-pair square root recurrence.
// ----------------------------------------------------------------------------
module isr_step #(
	parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF,
	parameter int STEPS      = (DATA_WIDTH - 2) / 2 + 1,
	parameter int SHIFT      = 0
) (
	input  logic [DATA_WIDTH-1:0] rad,
	input  logic [DATA_WIDTH-1:0] term,
	input  logic [STEPS-1:0]      root,
	output logic [DATA_WIDTH-1:0] next_rad,
	output logic [DATA_WIDTH-1:0] next_term,
	output logic [STEPS-1:0]      next_root
);

	// Weight of the bit pair tested in this step.
	localparam logic [DATA_WIDTH:0] WEIGHT = (DATA_WIDTH + 1)'(1) << SHIFT;

	logic [DATA_WIDTH:0]   trial;
	logic                  take;
	logic [DATA_WIDTH-1:0] term_sh;

	always_comb begin
		trial     = {1'b0, term} + WEIGHT;
		take      = ({1'b0, rad} >= trial);
		term_sh   = term >> 1;
		next_term = take ? (term_sh | WEIGHT[DATA_WIDTH-1:0]) : term_sh;
		next_rad  = take ? (rad - trial[DATA_WIDTH-1:0]) : rad;
		next_root = {root[STEPS-2:0], take};
	end

endmodule

### src/isr_pipe.sv
// ----------------------------------------------------------------------------
// isr_pipe
// Chain of register stages, one recurrence step per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isr_pipe #(
	parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [isr_pkg::VALUE_WIDTH-1:0]    value,
	output isr_pkg::beat_t                     tail
);

	localparam int STEPS = (DATA_WIDTH - 2) / 2 + 1;

	logic                  valid_s [1:STEPS];
	logic                  neg_s   [1:STEPS];
	logic [DATA_WIDTH-1:0] rad_s   [1:STEPS];
	logic [DATA_WIDTH-1:0] term_s  [1:STEPS];
	logic [STEPS-1:0]      root_s  [1:STEPS];

	// A negative radicand is replaced by zero so that its root comes out zero.
	logic                  neg_in;
	logic [DATA_WIDTH-1:0] rad_in;

	assign neg_in = value[DATA_WIDTH-1];
	assign rad_in = neg_in ? '0 : value[DATA_WIDTH-1:0];

	for (genvar k = 1; k <= STEPS; k++) begin : g_stage
		logic                  prev_valid;
		logic                  prev_neg;
		logic [DATA_WIDTH-1:0] prev_rad;
		logic [DATA_WIDTH-1:0] prev_term;
		logic [STEPS-1:0]      prev_root;
		logic [DATA_WIDTH-1:0] nxt_rad;
		logic [DATA_WIDTH-1:0] nxt_term;
		logic [STEPS-1:0]      nxt_root;

		if (k == 1) begin : g_first
			assign prev_valid = in_valid;
			assign prev_neg   = neg_in;
			assign prev_rad   = rad_in;
			assign prev_term  = '0;
			assign prev_root  = '0;
		end else begin : g_next
			assign prev_valid = valid_s[k-1];
			assign prev_neg   = neg_s[k-1];
			assign prev_rad   = rad_s[k-1];
			assign prev_term  = term_s[k-1];
			assign prev_root  = root_s[k-1];
		end

		isr_step #(
			.DATA_WIDTH (DATA_WIDTH),
			.STEPS      (STEPS),
			.SHIFT      (2 * (STEPS - k))
		) u_step (
			.rad       (prev_rad),
			.term      (prev_term),
			.root      (prev_root),
			.next_rad  (nxt_rad),
			.next_term (nxt_term),
			.next_root (nxt_root)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k]  <= prev_neg;
				rad_s[k]  <= nxt_rad;
				term_s[k] <= nxt_term;
				root_s[k] <= nxt_root;
			end
		end
	end

	assign tail.valid                 = valid_s[STEPS];
	assign tail.result.negative_error = neg_s[STEPS];
	assign tail.result.root           = isr_pkg::ROOT_WIDTH'(root_s[STEPS]);

	`ISR_ASSERT(a_neg_root_zero, valid_s[STEPS] && neg_s[STEPS] |-> root_s[STEPS] == '0, "negative radicand left a nonzero root")
	`ISR_ASSERT(a_tail_holds, !en && valid_s[STEPS] |=> valid_s[STEPS] && $stable(root_s[STEPS]), "pipeline tail moved while stalled")

endmodule

### src/isr_skid.sv
// ----------------------------------------------------------------------------
// isr_skid
// Output register with a skid entry, so the pipeline stall is registered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isr_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  isr_pkg::beat_t   tail,
	output logic             ready,
	output logic             out_valid,
	input  logic             out_ready,
	output isr_pkg::result_t out_result
);

	logic             out_valid_q;
	isr_pkg::result_t out_result_q;
	logic             skid_valid_q;
	isr_pkg::result_t skid_result_q;
	logic             take_in;
	logic             out_free;

	// The pipeline only moves while the skid entry is empty.
	assign ready    = !skid_valid_q;
	assign take_in  = tail.valid && ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take_in) begin
				out_valid_q <= 1'b1;
				if (!out_free) begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_ready && out_valid_q) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in && out_free) begin
			out_result_q <= tail.result;
		end else if (take_in) begin
			skid_result_q <= tail.result;
		end else if (out_ready && out_valid_q && skid_valid_q) begin
			out_result_q <= skid_result_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;

	`ISR_NEVER(a_skid_needs_out, skid_valid_q && !out_valid_q, "skid entry full while output register empty")
	`ISR_ASSERT(a_skid_fill_cause, $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready), "skid entry filled without a stalled output")

endmodule
